FILE: design/ymbf_pkg.sv
// Package for the YMODEM-1K block framer: request codes, block kinds,
// sequencer states, frame byte constants and the structs passed between modules.
// No dependencies.
`default_nettype none

package ymbf_pkg;

   localparam int HEADER_BLOCK_BYTES = 128;
   localparam int REP_W              = 10;
   localparam int CRC_CNT_W          = 4;

   localparam logic [15:0]          CRC_POLY   = 16'h1021;
   localparam logic [CRC_CNT_W-1:0] CRC_BITS   = 4'd8;
   localparam logic [7:0]           MARK_SOH   = 8'h01;
   localparam logic [7:0]           MARK_STX   = 8'h02;
   localparam logic [7:0]           MARK_EOT   = 8'h04;
   localparam logic [7:0]           PAD_DATA   = 8'h1A;
   localparam logic [7:0]           PAD_HEADER = 8'h00;
   localparam logic [7:0]           HDR_NUMBER = 8'h00;

   typedef enum logic [1:0] {
      REQ_DATA      = 2'd0,
      REQ_HEADER    = 2'd1,
      REQ_EMPTY_HDR = 2'd2,
      REQ_EOT       = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_HEADER = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_BYTE_WAIT,
      S_OPEN_MARK,
      S_OPEN_NUM,
      S_OPEN_INV,
      S_CLOSE,
      S_PAD,
      S_PAD_EMIT,
      S_CRC_HI,
      S_CRC_LO
   } state_type;

   typedef struct packed {
      logic [7:0]       frame_byte;
      logic [REP_W-1:0] repeat_count;
      logic             frame_done;
   } rsp_item_type;

   typedef struct packed {
      logic       clear;
      logic       start;
      logic [7:0] data;
   } crc_cmd_type;

endpackage

`default_nettype wire

FILE: design/ymbf_crc.sv
// Bit-serial CRC-16/XMODEM unit: shifts one data bit per cycle into the CRC.
// Depends on ymbf_pkg.
`default_nettype none

module ymbf_crc
   import ymbf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire crc_cmd_type cmd,
   output logic             busy,
   output logic [15:0]      crc
);

   logic [15:0]          crc_ff,  crc_in;
   logic [7:0]           data_ff, data_in;
   logic [CRC_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 fb;

   assign busy = (cnt_ff != '0);
   assign crc  = crc_ff;
   assign fb   = crc_ff[15] ^ data_ff[7];

   always_comb begin
      crc_in  = crc_ff;
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (cmd.clear) begin
         crc_in = '0;
      end else if (busy) begin
         crc_in = {crc_ff[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      if (cmd.start) begin
         data_in = cmd.data;
         cnt_in  = CRC_BITS;
      end else if (busy) begin
         data_in = {data_ff[6:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
      data_ff <= data_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy)
      else $error("crc start while busy");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !busy && !cmd.start)
      else $error("crc clear during operation");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CRC_BITS)
      else $error("crc bit count out of range");

endmodule

`default_nettype wire

FILE: design/ymbf_rsp_reg.sv
// Output register for result items; frees the sequencer while the receiver stalls.
// Depends on ymbf_pkg.
`default_nettype none

module ymbf_rsp_reg
   import ymbf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output logic              push_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff,  item_in;

   assign push_ready = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push && push_ready) begin
         valid_in = 1'b1;
         item_in  = push_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

FILE: design/ymbf_seq.sv
// Framing sequencer: block state, headers, padding loop and CRC trailer.
// Depends on ymbf_pkg; drives ymbf_crc through a command struct.
`default_nettype none

module ymbf_seq
   import ymbf_pkg::*;
#(
   parameter int DATA_BLOCK_BYTES = 1024
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic [7:0]   req_payload,
   input  wire logic         req_block_end,
   output crc_cmd_type       crc_cmd,
   input  wire logic         crc_busy,
   input  wire logic [15:0]  crc,
   output logic              push,
   output rsp_item_type      push_item,
   input  wire logic         push_ready
);

   localparam int CNT_W = $clog2(DATA_BLOCK_BYTES + 1);
   localparam logic [CNT_W-1:0] DATA_SIZE = CNT_W'(DATA_BLOCK_BYTES);
   localparam logic [CNT_W-1:0] HDR_SIZE  = CNT_W'(HEADER_BLOCK_BYTES);
   localparam logic [7:0] DATA_MARK = (DATA_BLOCK_BYTES == 128) ? MARK_SOH : MARK_STX;

   state_type    state_ff, state_in;
   kind_type     kind_ff,  kind_in;
   req_code_type type_ff,  type_in;
   logic [7:0]   byte_ff,  byte_in;
   logic         last_ff,  last_in;
   logic         phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pad_ff,   pad_in;
   logic [7:0]   blknum_ff, blknum_in;

   kind_type         want;
   logic [CNT_W-1:0] size;
   logic [7:0]       fill;
   logic [7:0]       hdr_num;

   assign want    = (type_ff == REQ_DATA) ? KIND_DATA : KIND_HEADER;
   assign size    = (kind_ff == KIND_DATA) ? DATA_SIZE : HDR_SIZE;
   assign fill    = (kind_ff == KIND_DATA) ? PAD_DATA : PAD_HEADER;
   assign hdr_num = (kind_ff == KIND_DATA) ? blknum_ff : HDR_NUMBER;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kind_ff   <= KIND_NONE;
         count_ff  <= '0;
         blknum_ff <= 8'd1;
         phase_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         count_ff  <= count_in;
         blknum_ff <= blknum_in;
         phase_ff  <= phase_in;
      end
      type_ff <= type_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      pad_ff  <= pad_in;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      type_in   = type_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      pad_in    = pad_ff;
      blknum_in = blknum_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      push_item = '{frame_byte: 8'h00, repeat_count: REP_W'(1), frame_done: 1'b0};
      crc_cmd   = '{clear: 1'b0, start: 1'b0, data: 8'h00};

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in  = req_code_type'(req_type);
               byte_in  = req_payload;
               last_in  = req_block_end;
               phase_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (type_ff)
               REQ_DATA, REQ_HEADER: begin
                  if (phase_ff) begin
                     state_in = S_IDLE;
                  end else if (kind_ff != KIND_NONE && kind_ff != want) begin
                     state_in = S_CLOSE;
                  end else if (kind_ff == KIND_NONE) begin
                     kind_in       = want;
                     count_in      = '0;
                     crc_cmd.clear = 1'b1;
                     state_in      = S_OPEN_MARK;
                  end else if (push_ready) begin
                     push                 = 1'b1;
                     push_item.frame_byte = byte_ff;
                     crc_cmd.start        = 1'b1;
                     crc_cmd.data         = byte_ff;
                     count_in             = count_ff + 1'b1;
                     phase_in             = 1'b1;
                     state_in             = S_BYTE_WAIT;
                  end
               end
               REQ_EMPTY_HDR: begin
                  if (kind_ff != KIND_NONE) begin
                     state_in = S_CLOSE;
                  end else if (phase_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     kind_in       = KIND_HEADER;
                     count_in      = '0;
                     crc_cmd.clear = 1'b1;
                     phase_in      = 1'b1;
                     state_in      = S_OPEN_MARK;
                  end
               end
               default: begin
                  if (kind_ff != KIND_NONE) begin
                     state_in = S_CLOSE;
                  end else if (push_ready) begin
                     push                 = 1'b1;
                     push_item.frame_byte = MARK_EOT;
                     push_item.frame_done = 1'b1;
                     state_in             = S_IDLE;
                  end
               end
            endcase
         end
         S_BYTE_WAIT: begin
            if (!crc_busy) begin
               state_in = (last_ff || count_ff >= size) ? S_CLOSE : S_IDLE;
            end
         end
         S_OPEN_MARK: begin
            if (push_ready) begin
               push                 = 1'b1;
               push_item.frame_byte = (kind_ff == KIND_DATA) ? DATA_MARK : MARK_SOH;
               state_in             = S_OPEN_NUM;
            end
         end
         S_OPEN_NUM: begin
            if (push_ready) begin
               push                 = 1'b1;
               push_item.frame_byte = hdr_num;
               state_in             = S_OPEN_INV;
            end
         end
         S_OPEN_INV: begin
            if (push_ready) begin
               push                 = 1'b1;
               push_item.frame_byte = ~hdr_num;
               state_in             = S_DISPATCH;
            end
         end
         S_CLOSE: begin
            pad_in = size - count_ff;
            if (count_ff < size) begin
               crc_cmd.start = 1'b1;
               crc_cmd.data  = fill;
               count_in      = count_ff + 1'b1;
               state_in      = S_PAD;
            end else begin
               state_in = S_CRC_HI;
            end
         end
         S_PAD: begin
            if (!crc_busy) begin
               if (count_ff < size) begin
                  crc_cmd.start = 1'b1;
                  crc_cmd.data  = fill;
                  count_in      = count_ff + 1'b1;
               end else begin
                  state_in = S_PAD_EMIT;
               end
            end
         end
         S_PAD_EMIT: begin
            if (push_ready) begin
               push                   = 1'b1;
               push_item.frame_byte   = fill;
               push_item.repeat_count = REP_W'(pad_ff);
               state_in               = S_CRC_HI;
            end
         end
         S_CRC_HI: begin
            if (push_ready) begin
               push                 = 1'b1;
               push_item.frame_byte = crc[15:8];
               state_in             = S_CRC_LO;
            end
         end
         S_CRC_LO: begin
            if (push_ready) begin
               push                 = 1'b1;
               push_item.frame_byte = crc[7:0];
               push_item.frame_done = 1'b1;
               blknum_in            = (kind_ff == KIND_DATA) ? blknum_ff + 8'd1 : 8'd1;
               kind_in              = KIND_NONE;
               count_in             = '0;
               crc_cmd.clear        = 1'b1;
               state_in             = S_DISPATCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_idle_crc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !crc_busy)
      else $error("crc busy while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= size)
      else $error("block byte count beyond block size");

   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("result pushed into full output register");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      kind_ff == KIND_NONE |-> count_ff == '0)
      else $error("byte count left over with no block open");

endmodule

`default_nettype wire

FILE: design/ymodem_block_framer_top.sv
// YMODEM-1K block framer, top level.
// Instantiates ymbf_seq, ymbf_crc and ymbf_rsp_reg; uses ymbf_pkg.
//
// Usage:
//   req_* channel: one item per request. req_type 0 sends a data byte, 1 a
//   header byte, 2 an empty header block, 3 end of transmission. req_payload
//   and req_block_end matter for kinds 0 and 1 only.
//   rsp_* channel: one item per frame byte, or one item for a run of pad
//   bytes (rsp_repeat_count gives the run length). rsp_frame_done marks the CRC low byte and EOT.
// Timing:
//   One item is worked on at a time; req_ready is high only while idle.
//   A data byte inside an open block passes the idle state, dispatch with the
//   output push, and a wait on the bit-serial CRC, one bit per cycle, before
//   the next request is accepted. Opening a block pushes the mark, the block
//   number and its inverse; closing feeds each pad byte through the CRC, then
//   pushes one item for any padding run and the two CRC bytes. Each push waits
//   for a free output register and shows on rsp_* in the next cycle.
// Reset: synchronous; no block open, CRC zero, next block number 1.
// Stall: one result waits in the output register; the sequencer holds on
//   the next result until rsp_ready frees the register.
`default_nettype none

module ymodem_block_framer_top
   import ymbf_pkg::*;
#(
   parameter int DATA_BLOCK_BYTES = 1024
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_type,
   input  wire logic [7:0]         req_payload,
   input  wire logic               req_block_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_frame_byte,
   output logic [REP_W-1:0]        rsp_repeat_count,
   output logic                    rsp_frame_done
);

   crc_cmd_type  crc_cmd;
   logic         crc_busy;
   logic [15:0]  crc;
   logic         push;
   logic         push_ready;
   rsp_item_type push_item;
   rsp_item_type rsp_item;

   ymbf_seq #(
      .DATA_BLOCK_BYTES (DATA_BLOCK_BYTES)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_payload   (req_payload),
      .req_block_end (req_block_end),
      .crc_cmd       (crc_cmd),
      .crc_busy      (crc_busy),
      .crc           (crc),
      .push          (push),
      .push_item     (push_item),
      .push_ready    (push_ready)
   );

   ymbf_crc u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .busy  (crc_busy),
      .crc   (crc)
   );

   ymbf_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_frame_byte   = rsp_item.frame_byte;
   assign rsp_repeat_count = rsp_item.repeat_count;
   assign rsp_frame_done   = rsp_item.frame_done;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || !push)
      else $error("item accepted while sequencer pushes");

   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != '0)
      else $error("zero repeat count on result");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_repeat_count == REP_W'(1))
      else $error("frame end carries a repeat run");

endmodule

`default_nettype wire

FILE: verif/ymodem_block_framer_top_test.sv
// Self-checking testbench for ymodem_block_framer_top: drives byte requests, predicts the
// YMODEM frame bytes (marks, numbers, padding runs, CRC-16/XMODEM) and checks every item.
// Depends on ymbf_pkg and the framer RTL.
`default_nettype none

module ymodem_block_framer_top_test
   import ymbf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_BYTES = 1024;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_type;
   logic [7:0]       req_payload;
   logic             req_block_end;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [7:0]       rsp_frame_byte;
   logic [REP_W-1:0] rsp_repeat_count;
   logic             rsp_frame_done;

   rsp_item_type expected_frames[$];
   int           error_count = 0;
   bit           idle_enable = 1'b1;

   // framer state as predicted
   logic [15:0] model_crc;
   logic [10:0] model_fill;
   logic [7:0]  model_block_num;
   kind_type    model_kind;

   ymodem_block_framer_top #(.DATA_BLOCK_BYTES(DATA_BYTES)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_payload      (req_payload),
      .req_block_end    (req_block_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_frame_done   (rsp_frame_done)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic void push_frame(logic [7:0] b, int rep, logic done);
      rsp_item_type f;
      f.frame_byte   = b;
      f.repeat_count = rep[REP_W-1:0];
      f.frame_done   = done;
      expected_frames.push_back(f);
   endfunction

   function automatic void close_frame_model();
      int         size;
      int         pad;
      logic [7:0] fill;
      if (model_kind == KIND_NONE) return;
      size = (model_kind == KIND_DATA) ? DATA_BYTES : HEADER_BLOCK_BYTES;
      fill = (model_kind == KIND_DATA) ? PAD_DATA : PAD_HEADER;
      pad  = (int'(model_fill) < size) ? size - int'(model_fill) : 0;
      for (int i = 0; i < pad; i++) begin
         model_crc = crc16_byte(model_crc, fill);
      end
      if (pad > 0) push_frame(fill, pad, 1'b0);
      push_frame(model_crc[15:8], 1, 1'b0);
      push_frame(model_crc[7:0], 1, 1'b1);
      if (model_kind == KIND_DATA) model_block_num = model_block_num + 8'd1;
      else model_block_num = 8'd1;
      model_kind = KIND_NONE;
      model_fill = '0;
      model_crc  = '0;
   endfunction

   function automatic void open_frame_model(kind_type kind);
      if (kind == KIND_DATA) begin
         push_frame((DATA_BYTES == 128) ? MARK_SOH : MARK_STX, 1, 1'b0);
         push_frame(model_block_num, 1, 1'b0);
         push_frame(~model_block_num, 1, 1'b0);
      end else begin
         push_frame(MARK_SOH, 1, 1'b0);
         push_frame(HDR_NUMBER, 1, 1'b0);
         push_frame(~HDR_NUMBER, 1, 1'b0);
      end
      model_kind = kind;
      model_fill = '0;
      model_crc  = '0;
   endfunction

   function automatic void predict_frames(req_code_type code, logic [7:0] b, logic last);
      kind_type kind;
      int       size;
      if (code == REQ_DATA || code == REQ_HEADER) begin
         kind = (code == REQ_DATA) ? KIND_DATA : KIND_HEADER;
         size = (code == REQ_DATA) ? DATA_BYTES : HEADER_BLOCK_BYTES;
         if (model_kind != KIND_NONE && model_kind != kind) close_frame_model();
         if (model_kind == KIND_NONE) open_frame_model(kind);
         push_frame(b, 1, 1'b0);
         model_crc  = crc16_byte(model_crc, b);
         model_fill = model_fill + 11'd1;
         if (last || int'(model_fill) >= size) close_frame_model();
      end else if (code == REQ_EMPTY_HDR) begin
         close_frame_model();
         open_frame_model(KIND_HEADER);
         close_frame_model();
      end else begin
         close_frame_model();
         push_frame(MARK_EOT, 1, 1'b1);
      end
   endfunction

   task automatic send_req(req_code_type code, logic [7:0] b, logic last);
      @(negedge clock);
      while (idle_enable && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= code;
      req_payload   <= b;
      req_block_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_frames(code, b, last);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= !idle_enable || ($urandom_range(0, 99) >= 33);
   end

   always @(posedge clock) begin
      rsp_item_type exp_f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected item: frame_byte %h repeat_count %0d frame_done %b",
                   rsp_frame_byte, rsp_repeat_count, rsp_frame_done);
            error_count++;
         end else begin
            exp_f = expected_frames.pop_front();
            if (rsp_frame_byte !== exp_f.frame_byte) begin
               $error("frame_byte: expected %h, got %h", exp_f.frame_byte, rsp_frame_byte);
               error_count++;
            end
            if (rsp_repeat_count !== exp_f.repeat_count) begin
               $error("repeat_count: expected %0d, got %0d",
                      exp_f.repeat_count, rsp_repeat_count);
               error_count++;
            end
            if (rsp_frame_done !== exp_f.frame_done) begin
               $error("frame_done: expected %b, got %b", exp_f.frame_done, rsp_frame_done);
               error_count++;
            end
         end
      end
   end

   // blocks of one or two items, payload extremes, terminating frames with nothing open
   task automatic test_single_blocks();
      send_req(REQ_DATA, 8'h00, 1'b1);
      send_req(REQ_DATA, 8'hFF, 1'b0);
      send_req(REQ_DATA, 8'hA5, 1'b1);
      send_req(REQ_HEADER, 8'h80, 1'b1);
      send_req(REQ_EMPTY_HDR, 8'hFF, 1'b1);
      send_req(REQ_EOT, 8'h00, 1'b0);
      wait_drained();
   endtask

   task automatic test_kind_changes();
      send_req(REQ_DATA, 8'h3C, 1'b0);
      send_req(REQ_HEADER, 8'h7E, 1'b0);
      send_req(REQ_DATA, 8'h01, 1'b0);
      send_req(REQ_EOT, 8'hFF, 1'b1);
      send_req(REQ_HEADER, 8'hC3, 1'b0);
      send_req(REQ_EMPTY_HDR, 8'h00, 1'b0);
      send_req(REQ_DATA, 8'h5A, 1'b0);
      send_req(REQ_EMPTY_HDR, 8'hAA, 1'b1);
      send_req(REQ_HEADER, 8'h11, 1'b0);
      send_req(REQ_EOT, 8'h55, 1'b0);
      send_req(REQ_EOT, 8'h00, 1'b1);
      send_req(REQ_DATA, 8'h80, 1'b0);
      send_req(REQ_HEADER, 8'h01, 1'b1);
      wait_drained();
   endtask

   // a header block that closes on size alone, no padding run
   task automatic test_full_blocks();
      for (int i = 0; i < HEADER_BLOCK_BYTES; i++) begin
         send_req(REQ_HEADER, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_req(REQ_EOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int sent;
      int len;
      int pick;
      bit drained;
      sent    = 0;
      drained = 1'b0;
      while (sent < 20) begin
         idle_enable = !(sent >= 4 && sent < 12);
         if (!drained && sent >= 14) begin
            wait_drained();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_req(REQ_DATA, 8'($urandom_range(0, 255)), i == len - 1);
            end
         end else if (pick < 58) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               send_req(REQ_DATA, 8'($urandom_range(0, 255)), 1'b0);
            end
         end else if (pick < 73) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               send_req(REQ_HEADER, 8'($urandom_range(0, 255)), i == len - 1);
            end
         end else if (pick < 80) begin
            len = 1;
            send_req(REQ_EMPTY_HDR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 88) begin
            len = 1;
            send_req(REQ_EOT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               send_req(req_code_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
            end
         end
         sent += len;
      end
      idle_enable = 1'b1;
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_DATA;
      req_payload     = 8'h00;
      req_block_end   = 1'b0;
      rsp_ready       = 1'b0;
      model_crc       = '0;
      model_fill      = '0;
      model_block_num = 8'd1;
      model_kind      = KIND_NONE;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_blocks();
      test_kind_changes();
      test_full_blocks();
      test_random_traffic();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
